/* sv/ips_pkg.sv */
// Shared types, mode codes and arithmetic helpers of the inverter power sequencer.
package ips_pkg;

  localparam int TIMER_BITS = 24;
  localparam int REF_BITS   = 23;
  localparam int CFG_BITS   = 16;
  localparam int CFG_IDX_BITS = 4;
  localparam int MODE_BITS  = 4;
  localparam int DIR_BITS   = 2;
  localparam int IN_BYTES   = 13;
  localparam int OUT_BYTES  = 8;
  localparam int IN_PAD     = IN_BYTES * 8 - (16 * 4 + 7 + 2 * REF_BITS - 16);
  localparam int OUT_PAD    = OUT_BYTES * 8 - (MODE_BITS + 2 + 4 + DIR_BITS + 2 + 2 * REF_BITS);

  // Sequencer mode codes
  localparam logic [MODE_BITS-1:0] MODE_STANDBY   = 4'd0;
  localparam logic [MODE_BITS-1:0] MODE_PRECHARGE = 4'd1;
  localparam logic [MODE_BITS-1:0] MODE_READY     = 4'd2;
  localparam logic [MODE_BITS-1:0] MODE_SYNC      = 4'd3;
  localparam logic [MODE_BITS-1:0] MODE_INVERTER  = 4'd4;
  localparam logic [MODE_BITS-1:0] MODE_RECTIFIER = 4'd5;
  localparam logic [MODE_BITS-1:0] MODE_STOPPING  = 4'd6;
  localparam logic [MODE_BITS-1:0] MODE_FAULT     = 4'd7;
  localparam logic [MODE_BITS-1:0] MODE_EMERGENCY = 4'd8;

  // Power direction codes
  localparam logic [DIR_BITS-1:0] DIR_IDLE = 2'd0;
  localparam logic [DIR_BITS-1:0] DIR_INV  = 2'd1;
  localparam logic [DIR_BITS-1:0] DIR_REC  = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_DC_PRESENT_THR = 4'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_PRECHARGE_TO   = 4'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_GRID_SYNC_TO   = 4'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_STOP_POWER_THR = 4'd3;

  // 0.9 in Q15
  localparam logic [14:0] DECAY_Q15 = 15'd29491;

  typedef struct packed {
    logic [CFG_BITS-1:0] dc_present_threshold;
    logic [CFG_BITS-1:0] precharge_timeout;
    logic [CFG_BITS-1:0] grid_sync_timeout;
    logic [CFG_BITS-1:0] stop_power_threshold;
  } ips_cfg_t;

  // Input beat layout, lowest field last
  typedef struct packed {
    logic [IN_PAD-1:0]          pad;
    logic signed [REF_BITS-1:0] reactive_power_ref;
    logic signed [REF_BITS-1:0] active_power_ref;
    logic                       pll_lock;
    logic                       grid_ok;
    logic [15:0]                battery_voltage;
    logic [15:0]                dc_voltage;
    logic                       fault_reset;
    logic                       fast_trip;
    logic                       slow_fault;
    logic                       enable_request;
    logic                       estop_active;
    logic [15:0]                elapsed_ms;
  } ips_in_t;

  // Result beat layout, lowest field last
  typedef struct packed {
    logic [OUT_PAD-1:0]         pad;
    logic signed [REF_BITS-1:0] reactive_ref_out;
    logic signed [REF_BITS-1:0] active_ref_out;
    logic                       control_reset_pulse;
    logic                       pll_reset_pulse;
    logic [DIR_BITS-1:0]        power_direction;
    logic                       pwm_enable;
    logic                       grid_relay;
    logic                       main_relay;
    logic                       precharge_relay;
    logic [1:0]                 fault_bits;
    logic [MODE_BITS-1:0]       mode_code;
  } ips_out_t;

  typedef struct packed {
    logic [MODE_BITS-1:0]       mode;
    logic [TIMER_BITS-1:0]      timer;
    logic                       estop_latch;
    logic                       pfail_latch;
    logic                       rly_pre;
    logic                       rly_main;
    logic                       rly_grid;
    logic                       pwm_on;
    logic [DIR_BITS-1:0]        dir;
    logic signed [REF_BITS-1:0] ramp_p;
    logic signed [REF_BITS-1:0] ramp_q;
  } ips_state_t;

  function automatic logic [REF_BITS-1:0] ref_mag(input logic signed [REF_BITS-1:0] x);
    ref_mag = x[REF_BITS-1] ? REF_BITS'(-x) : REF_BITS'(x);
  endfunction

  // Scale by 0.9 with the magnitude truncated, so the value reaches zero
  function automatic logic signed [REF_BITS-1:0] ref_decay(
      input logic signed [REF_BITS-1:0] x);
    logic [REF_BITS-1:0]    mag;
    logic [REF_BITS+14:0]   prod;
    logic [REF_BITS-1:0]    m;
    mag  = ref_mag(x);
    prod = (REF_BITS+15)'(mag) * (REF_BITS+15)'(DECAY_Q15);
    m    = prod[REF_BITS+14:15];
    ref_decay = x[REF_BITS-1] ? $signed(REF_BITS'(-m)) : $signed(m);
  endfunction

  // Saturating timer advance
  function automatic logic [TIMER_BITS-1:0] timer_add(input logic [TIMER_BITS-1:0] t,
                                                      input logic [15:0] ms);
    logic [TIMER_BITS:0] sum;
    sum = (TIMER_BITS+1)'(t) + (TIMER_BITS+1)'(ms);
    timer_add = sum[TIMER_BITS] ? {TIMER_BITS{1'b1}} : sum[TIMER_BITS-1:0];
  endfunction

endpackage

/* sv/ips_cfg.sv */
// Configuration register file of the inverter power sequencer.
module ips_cfg
  import ips_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0] cfg_idx_i,
  input  logic [CFG_BITS-1:0]     cfg_wdata_i,
  output ips_cfg_t                cfg_o
);

  ips_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_DC_PRESENT_THR: cfg_d.dc_present_threshold = cfg_wdata_i;
        REG_PRECHARGE_TO:   cfg_d.precharge_timeout    = cfg_wdata_i;
        REG_GRID_SYNC_TO:   cfg_d.grid_sync_timeout    = cfg_wdata_i;
        REG_STOP_POWER_THR: cfg_d.stop_power_threshold = cfg_wdata_i;
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dc_present_threshold <= 16'd2500;
      cfg_q.precharge_timeout    <= 16'd5000;
      cfg_q.grid_sync_timeout    <= 16'd2000;
      cfg_q.stop_power_threshold <= 16'd100;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* sv/ips_step.sv */
// Next-state and result logic for one supervision tick.
module ips_step
  import ips_pkg::*;
(
  input  ips_state_t st_i,
  input  ips_cfg_t   cfg_i,
  input  ips_in_t    item_i,
  output ips_state_t st_o,
  output ips_out_t   res_o
);

  ips_state_t          nxt;
  logic                any_fault;
  logic                ramped;
  logic                pll_p;
  logic                ctl_p;
  logic                pref_neg;
  logic                pre_done;
  logic [20:0]         vdc_x20;
  logic [20:0]         vbat_x19;
  logic [TIMER_BITS-1:0] tim_adv;
  logic signed [REF_BITS-1:0] dec_p;
  logic signed [REF_BITS-1:0] dec_q;

  assign vdc_x20  = 21'(item_i.dc_voltage) * 21'd20;
  assign vbat_x19 = 21'(item_i.battery_voltage) * 21'd19;
  assign pre_done = vdc_x20 >= vbat_x19;
  assign pref_neg = item_i.active_power_ref[REF_BITS-1];
  assign tim_adv  = timer_add(st_i.timer, item_i.elapsed_ms);
  assign dec_p    = ref_decay(st_i.ramp_p);
  assign dec_q    = ref_decay(st_i.ramp_q);

  always_comb begin
    nxt       = st_i;
    ramped    = 1'b0;
    pll_p     = 1'b0;
    ctl_p     = 1'b0;
    any_fault = 1'b0;

    if (item_i.fault_reset) begin
      nxt.pfail_latch = 1'b0;
    end

    if (item_i.estop_active) begin
      nxt.estop_latch = 1'b1;
      nxt.mode        = MODE_EMERGENCY;
      nxt.pwm_on      = 1'b0;
      nxt.rly_pre     = 1'b0;
      nxt.rly_main    = 1'b0;
      nxt.rly_grid    = 1'b0;
    end else begin
      if (item_i.fast_trip && st_i.mode != MODE_EMERGENCY) begin
        nxt.pwm_on = 1'b0;
        nxt.mode   = MODE_FAULT;
      end
      any_fault = item_i.slow_fault | item_i.fast_trip | nxt.estop_latch | nxt.pfail_latch;

      case (nxt.mode)
        MODE_STANDBY: begin
          if (item_i.enable_request && !any_fault &&
              item_i.dc_voltage > cfg_i.dc_present_threshold) begin
            nxt.mode    = MODE_PRECHARGE;
            nxt.timer   = '0;
            nxt.rly_pre = 1'b1;
          end
        end
        MODE_PRECHARGE: begin
          nxt.timer = tim_adv;
          if (pre_done) begin
            nxt.rly_main = 1'b1;
            nxt.rly_pre  = 1'b0;
            nxt.mode     = MODE_READY;
            nxt.timer    = '0;
          end else if (tim_adv > TIMER_BITS'(cfg_i.precharge_timeout)) begin
            nxt.pfail_latch = 1'b1;
            nxt.mode        = MODE_FAULT;
            nxt.rly_pre     = 1'b0;
          end
        end
        MODE_READY: begin
          if (!item_i.enable_request) begin
            nxt.mode = MODE_STOPPING;
          end else if (item_i.grid_ok) begin
            nxt.mode  = MODE_SYNC;
            nxt.timer = '0;
            pll_p     = 1'b1;
          end
        end
        MODE_SYNC: begin
          nxt.timer = tim_adv;
          if (item_i.pll_lock) begin
            ctl_p        = 1'b1;
            nxt.pwm_on   = 1'b1;
            nxt.rly_grid = 1'b1;
            if (!pref_neg) begin
              nxt.mode = MODE_INVERTER;
              nxt.dir  = DIR_INV;
            end else begin
              nxt.mode = MODE_RECTIFIER;
              nxt.dir  = DIR_REC;
            end
          end else if (tim_adv > TIMER_BITS'(cfg_i.grid_sync_timeout)) begin
            nxt.mode = MODE_READY;
          end
        end
        MODE_INVERTER, MODE_RECTIFIER: begin
          // Leaving for stopping wins over a direction change
          if (!item_i.enable_request || any_fault) begin
            nxt.mode = MODE_STOPPING;
          end else if (nxt.mode == MODE_INVERTER && pref_neg) begin
            nxt.mode = MODE_RECTIFIER;
            nxt.dir  = DIR_REC;
          end else if (nxt.mode == MODE_RECTIFIER && !pref_neg) begin
            nxt.mode = MODE_INVERTER;
            nxt.dir  = DIR_INV;
          end
        end
        MODE_STOPPING: begin
          nxt.ramp_p = dec_p;
          nxt.ramp_q = dec_q;
          ramped     = 1'b1;
          if (ref_mag(dec_p) < REF_BITS'(cfg_i.stop_power_threshold)) begin
            nxt.pwm_on   = 1'b0;
            nxt.rly_grid = 1'b0;
            nxt.dir      = DIR_IDLE;
            nxt.mode     = MODE_READY;
          end
        end
        MODE_FAULT: begin
          nxt.pwm_on   = 1'b0;
          nxt.rly_grid = 1'b0;
          nxt.rly_main = 1'b0;
          nxt.dir      = DIR_IDLE;
          if (!any_fault && !item_i.enable_request) begin
            nxt.mode = MODE_STANDBY;
          end
        end
        MODE_EMERGENCY: begin
          nxt.pwm_on      = 1'b0;
          nxt.rly_pre     = 1'b0;
          nxt.rly_main    = 1'b0;
          nxt.rly_grid    = 1'b0;
          nxt.estop_latch = 1'b0;
          nxt.mode        = MODE_STANDBY;
        end
        default: begin
          nxt.mode = MODE_FAULT;
        end
      endcase
    end

    if (!ramped) begin
      nxt.ramp_p = item_i.active_power_ref;
      nxt.ramp_q = item_i.reactive_power_ref;
    end
  end

  assign st_o = nxt;

  always_comb begin
    res_o                     = '0;
    res_o.mode_code           = nxt.mode;
    res_o.fault_bits          = {nxt.pfail_latch, nxt.estop_latch};
    res_o.precharge_relay     = nxt.rly_pre;
    res_o.main_relay          = nxt.rly_main;
    res_o.grid_relay          = nxt.rly_grid;
    res_o.pwm_enable          = nxt.pwm_on;
    res_o.power_direction     = nxt.dir;
    res_o.pll_reset_pulse     = pll_p;
    res_o.control_reset_pulse = ctl_p;
    res_o.active_ref_out      = nxt.ramp_p;
    res_o.reactive_ref_out    = nxt.ramp_q;
  end

endmodule

/* sv/inverter_power_sequencer_top.sv */
// Top level of the inverter power sequencer: beat registers, state and handshake.
//
// One input beat is one tick of the slow supervision loop; one result beat comes
// back for every tick. A beat is taken into an input register, the sequencer
// step runs as one short pass of logic from that register and the sequencer
// state, and the result lands in an output register. A new tick is accepted every
// cycle while the input register is not full behind a waiting result. The state
// (mode, saturating phase timer, latched e-stop and precharge-failure bits,
// relay and PWM drives, direction, ramped references) advances only when a tick
// moves from the input register to the output register, which happens whenever
// the output register is empty or its beat is being taken. While a result waits
// downstream the input register still takes one more beat before the input
// side stalls. The only arithmetic in the pass is two 23 x 15 bit multiplies for
// the 0.9 stopping ramp of both references, two narrow constant multiplies for
// the 0.95 precharge check and a saturating 24-bit add. Configuration registers
// are written through the plain write port and should only be changed while no
// tick is in flight.
module inverter_power_sequencer_top
  import ips_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // Input beat, from bit 0 up: elapsed_ms[15:0], estop_active, enable_request,
  // slow_fault, fast_trip, fault_reset, dc_voltage[15:0], battery_voltage[15:0],
  // grid_ok, pll_lock, active_power_ref[22:0], reactive_power_ref[22:0], zero pad
  input  logic                    s_axis_tvalid_i,
  output logic                    s_axis_tready_o,
  input  logic [IN_BYTES*8-1:0]   s_axis_tdata_i,
  // Result beat, from bit 0 up: mode_code[3:0], fault_bits[1:0], precharge_relay,
  // main_relay, grid_relay, pwm_enable, power_direction[1:0], pll_reset_pulse,
  // control_reset_pulse, active_ref_out[22:0], reactive_ref_out[22:0], zero pad
  output logic                    m_axis_tvalid_o,
  input  logic                    m_axis_tready_i,
  output logic [OUT_BYTES*8-1:0]  m_axis_tdata_o,
  // Configuration write port
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0] cfg_idx_i,
  input  logic [CFG_BITS-1:0]     cfg_wdata_i
);

  ips_cfg_t   cfg;
  ips_in_t    in_q;
  logic       in_vld_q;
  ips_out_t   out_q;
  ips_out_t   res;
  logic       out_vld_q;
  ips_state_t st_q, st_d;
  logic       advance;
  logic       in_take;

  // Move a tick forward when the result slot is free or being emptied
  assign advance         = in_vld_q && (!out_vld_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_vld_q || advance;
  assign in_take         = s_axis_tvalid_i && s_axis_tready_o;

  ips_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  ips_step u_step (
    .st_i   (st_q),
    .cfg_i  (cfg),
    .item_i (in_q),
    .st_o   (st_d),
    .res_o  (res)
  );

  // Input register: hold the beat until it advances
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_vld_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= ips_in_t'(s_axis_tdata_i);
    end
  end

  // Sequencer state: advance once per tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.mode        <= MODE_STANDBY;
      st_q.timer       <= '0;
      st_q.estop_latch <= 1'b0;
      st_q.pfail_latch <= 1'b0;
      st_q.rly_pre     <= 1'b0;
      st_q.rly_main    <= 1'b0;
      st_q.rly_grid    <= 1'b0;
      st_q.pwm_on      <= 1'b0;
      st_q.dir         <= DIR_IDLE;
      st_q.ramp_p      <= '0;
      st_q.ramp_q      <= '0;
    end else if (advance) begin
      st_q <= st_d;
    end
  end

  // Output register: drop valid once the beat is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_q;

  // PWM only runs with the grid contactor closed
  a_pwm_needs_grid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.pwm_on |-> st_q.rly_grid)
    else $error("PWM enabled with grid relay open");

  // Precharge and main contactors are never closed together
  a_pre_main_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(st_q.rly_pre && st_q.rly_main))
    else $error("precharge and main relay closed together");

  // Emergency holds everything open and off
  a_emergency_safe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q.mode == MODE_EMERGENCY) |->
      (!st_q.pwm_on && !st_q.rly_pre && !st_q.rly_main && !st_q.rly_grid))
    else $error("emergency with a drive still active");

  // A PLL reset request only accompanies entry into sync
  a_pll_pulse_sync: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_q.pll_reset_pulse) |-> (out_q.mode_code == MODE_SYNC))
    else $error("PLL reset pulse outside sync entry");

  // A control reset request only accompanies entry into run
  a_ctl_pulse_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_q.control_reset_pulse) |->
      (out_q.mode_code == MODE_INVERTER || out_q.mode_code == MODE_RECTIFIER))
    else $error("control reset pulse outside run entry");

endmodule
